[design/tcw_pkg.sv]
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default geometry: 80 columns by 25 rows.
  localparam int unsigned DEF_CELLS   = 2000;
  localparam int unsigned DEF_COLUMNS = 80;

  // Fixed widths of the port fields.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned NIB_W    = 4;

  localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FILL = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NONE      = 8'h00;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h02;

  // Tab writes four spaces; the counter holds the spaces left minus one.
  localparam logic [1:0] TAB_LAST_SPACE = 2'd3;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_PUT    = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_READ   = 6'b100000
  } state_e;

endpackage

[design/text_console_writer.sv]
// Text console writer: character cell store, cursor and the sequencer that walks them.
`timescale 1ns / 1ps

// Usage. A request is taken at a clock edge where start is high and busy is low.
// req_type_i selects put character, read cell or fill area; the other fields
// go with it. Each request gives exactly one result: result_valid_o is high for
// one cycle with cursor_position_o and read_data_o. The receiver cannot stall;
// the result is accepted in the cycle it is shown.
// A new request can be accepted in the cycle that shows the previous result.
// A put request that finds the cursor at the end of the store first scrolls up
// one row. A fill writes its cells one per cycle. All store traffic goes through
// one memory port pair; clear, scroll and fill share one address counter.
// After reset the store is cleared one cell a cycle, with busy high. The
// attribute register is written through the cfg beat channel; the user is to
// write it only while the block is idle, which the block itself does not
// enforce. cfg_ready_o is always high. Reset value is 0x02.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned CELLS   = DEF_CELLS,
  parameter int unsigned COLUMNS = DEF_COLUMNS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [INDEX_W-1:0]  cell_index_i,
  input  logic [INDEX_W-1:0]  fill_length_i,
  input  logic [NIB_W-1:0]    background_i,
  input  logic [NIB_W-1:0]    foreground_i,
  output logic                result_valid_o,
  output logic [CURSOR_W-1:0] cursor_position_o,
  output logic [CELL_W-1:0]   read_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ATTR_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned CW = $clog2(CELLS + COLUMNS);
  localparam int unsigned LW = $clog2(COLUMNS);
  localparam int unsigned SW = $clog2(CELLS + COLUMNS + 1);
  localparam int unsigned IW = (SW > INDEX_W + 1) ? SW : INDEX_W + 1;

  state_e state_q, state_d;

  logic [CW-1:0]     cursor_q, cursor_d;
  logic [LW-1:0]     col_q, col_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     fill_end_q, fill_end_d;
  logic [ATTR_W-1:0] fill_attr_q, fill_attr_d;
  logic [ATTR_W-1:0] attr_q;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic [1:0]        tab_left_q, tab_left_d;
  logic              rd_ok_q, rd_ok_d;

  logic                res_valid_q, res_valid_d;
  logic [CURSOR_W-1:0] res_cursor_q, res_cursor_d;
  logic [CELL_W-1:0]   res_data_q, res_data_d;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic          accept;
  logic [IW-1:0] scroll_src;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign scroll_src  = cnt_q + IW'(COLUMNS);

  assign result_valid_o    = res_valid_q;
  assign cursor_position_o = res_cursor_q;
  assign read_data_o       = res_data_q;

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    col_d        = col_q;
    cnt_d        = cnt_q;
    fill_end_d   = fill_end_q;
    fill_attr_d  = fill_attr_q;
    req_d        = req_q;
    ch_d         = ch_q;
    tab_left_d   = tab_left_q;
    rd_ok_d      = rd_ok_q;
    res_valid_d  = 1'b0;
    res_cursor_d = res_cursor_q;
    res_data_d   = res_data_q;
    mem_we       = 1'b0;
    mem_waddr    = AW'(cnt_q);
    mem_wdata    = '0;
    mem_raddr    = AW'(cell_index_i);

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == IW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_d       = req_type_i;
          ch_d        = char_code_i;
          tab_left_d  = TAB_LAST_SPACE;
          rd_ok_d     = IW'(cell_index_i) < IW'(CELLS);
          cnt_d       = IW'(cell_index_i);
          fill_end_d  = IW'(cell_index_i) + IW'(fill_length_i);
          fill_attr_d = {background_i, foreground_i};
          unique case (req_type_i)
            REQ_PUT:  state_d = S_PUT;
            REQ_READ: state_d = S_READ;
            REQ_FILL: state_d = S_FILL;
            default: begin
              res_valid_d  = 1'b1;
              res_cursor_d = CURSOR_W'(cursor_q);
              res_data_d   = '0;
            end
          endcase
        end
      end

      S_PUT: begin
        if (cursor_q >= CW'(CELLS)) begin
          cnt_d   = '0;
          state_d = S_SCROLL;
        end else begin
          priority if (ch_q == CH_NEWLINE) begin
            cursor_d = cursor_q + CW'(COLUMNS) - CW'(col_q);
            col_d    = '0;
          end else if (ch_q == CH_BACKSPACE) begin
            if (cursor_q != '0) begin
              cursor_d  = cursor_q - 1'b1;
              col_d     = (col_q == '0) ? LW'(COLUMNS - 1) : col_q - 1'b1;
              mem_we    = 1'b1;
              mem_waddr = AW'(cursor_q - 1'b1);
              mem_wdata = {attr_q, CH_SPACE};
            end
          end else begin
            cursor_d  = cursor_q + 1'b1;
            col_d     = (col_q == LW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
            mem_we    = 1'b1;
            mem_waddr = AW'(cursor_q);
            mem_wdata = {attr_q, (ch_q == CH_TAB) ? CH_SPACE : ch_q};
          end
          // A tab stays here until its fourth space is written.
          if (ch_q == CH_TAB && tab_left_q != '0) begin
            tab_left_d = tab_left_q - 1'b1;
          end else begin
            res_valid_d  = 1'b1;
            res_cursor_d = CURSOR_W'(cursor_d);
            res_data_d   = '0;
            state_d      = S_IDLE;
          end
        end
      end

      S_SCROLL: begin
        // Cell cnt-1 takes the cell one row below it, read in the previous cycle.
        mem_raddr = AW'(scroll_src);
        mem_waddr = AW'(cnt_q - 1'b1);
        mem_wdata = (scroll_src > IW'(CELLS)) ? '0 : rdata_q;
        mem_we    = (cnt_q != '0);
        if (cnt_q == IW'(CELLS)) begin
          if (cursor_q >= CW'(COLUMNS)) begin
            cursor_d = cursor_q - CW'(COLUMNS);
          end else begin
            cursor_d = '0;
            col_d    = '0;
          end
          state_d = S_PUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_FILL: begin
        if (cnt_q < IW'(CELLS) && cnt_q < fill_end_q) begin
          mem_we    = 1'b1;
          mem_wdata = {fill_attr_q, CH_NONE};
          cnt_d     = cnt_q + 1'b1;
        end else begin
          res_valid_d  = 1'b1;
          res_cursor_d = CURSOR_W'(cursor_q);
          res_data_d   = '0;
          state_d      = S_IDLE;
        end
      end

      S_READ: begin
        res_valid_d  = 1'b1;
        res_cursor_d = CURSOR_W'(cursor_q);
        res_data_d   = rd_ok_q ? rdata_q : '0;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cursor_q    <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      tab_left_q  <= '0;
      res_valid_q <= 1'b0;
      attr_q      <= ATTR_RESET;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      tab_left_q  <= tab_left_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_end_q   <= fill_end_d;
    fill_attr_q  <= fill_attr_d;
    req_q        <= req_d;
    ch_q         <= ch_d;
    rd_ok_q      <= rd_ok_d;
    res_cursor_q <= res_cursor_d;
    res_data_q   <= res_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // The column register must track the cursor modulo the row length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(col_q) == cursor_q % CW'(COLUMNS)))
    else $error("column register out of step with cursor");

  // The store is never written while the block reports idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_we)
    else $error("store written while idle");

  // Every result beat follows an accepted request or work in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result beat without a request");

  // The put sequencer runs only for a put request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && req_q != REQ_PUT) |-> 1'b0)
    else $error("put sequencer running for another request type");

endmodule
